// ===== hdl/pftc_pkg.sv =====
// Shared types and constants of the polygon fan triangulator with culling.
package pftc_pkg;

  localparam int unsigned COORD_W  = 24;
  localparam int unsigned REF_W    = 14;
  localparam int unsigned PAL_W    = 6;
  localparam int unsigned CORNER_W = 12;
  localparam int unsigned THR_W    = 63;
  localparam int unsigned EDGE_W   = COORD_W + 1;
  localparam int unsigned PROD_W   = 2 * EDGE_W;
  localparam int unsigned CROSS_W  = PROD_W + 1;
  localparam int unsigned MAG_W    = 32;
  localparam int unsigned SQ_W     = 2 * MAG_W;
  localparam int unsigned SUM_W    = SQ_W + 2;
  localparam int unsigned QUEUE_AW = 2;

  localparam logic signed [PAL_W-1:0] PAL_FALLBACK = -6'sd1;
  localparam logic [THR_W-1:0]        THR_RESET    = 63'd1;

  typedef enum logic [1:0] {
    OP_VERTEX  = 2'd0,
    OP_FACE    = 2'd1,
    OP_PALETTE = 2'd2
  } op_e;

  typedef enum logic {
    KIND_TRI = 1'b0,
    KIND_ERR = 1'b1
  } kind_e;

  typedef enum logic {
    ERR_RANGE = 1'b0,
    ERR_FULL  = 1'b1
  } err_e;

  typedef struct packed {
    kind_e                    kind;
    err_e                     code;
    logic signed [PAL_W-1:0]  palette;
  } meta_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vertex_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_RDA,
    B_RDB,
    B_RDC,
    B_EDGE,
    B_MUL,
    B_CROSS,
    B_ABS,
    B_SQR,
    B_SUM,
    B_OUT
  } back_state_e;

endpackage

// ===== hdl/pftc_in_if.sv =====
// Directive channel: valid/ready handshake with one mesh directive as payload.
interface pftc_in_if;
  logic                                    valid;
  logic                                    ready;
  logic [1:0]                              opcode;
  logic signed [pftc_pkg::COORD_W-1:0]     pos_x;
  logic signed [pftc_pkg::COORD_W-1:0]     pos_y;
  logic signed [pftc_pkg::COORD_W-1:0]     pos_z;
  logic signed [pftc_pkg::REF_W-1:0]       vertex_ref;
  logic                                    first_of_face;
  logic signed [pftc_pkg::PAL_W-1:0]       palette_in;

  modport source (
    output valid, opcode, pos_x, pos_y, pos_z, vertex_ref, first_of_face, palette_in,
    input  ready
  );
  modport sink (
    input  valid, opcode, pos_x, pos_y, pos_z, vertex_ref, first_of_face, palette_in,
    output ready
  );
endinterface

// ===== hdl/pftc_out_if.sv =====
// Result channel: valid/ready handshake with one triangle or error report as payload.
interface pftc_out_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic [pftc_pkg::CORNER_W-1:0]       corner_a;
  logic [pftc_pkg::CORNER_W-1:0]       corner_b;
  logic [pftc_pkg::CORNER_W-1:0]       corner_c;
  logic signed [pftc_pkg::PAL_W-1:0]   tri_palette;
  logic                                error_code;

  modport source (
    output valid, kind, corner_a, corner_b, corner_c, tri_palette, error_code,
    input  ready
  );
  modport sink (
    input  valid, kind, corner_a, corner_b, corner_c, tri_palette, error_code,
    output ready
  );
endinterface

// ===== hdl/pftc_queue.sv =====
// Small register queue that carries fan commands from the front end to the back end.
module pftc_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned AddrW = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  input  logic             pop_i,
  output logic [Width-1:0] head_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int unsigned Depth = 2 ** AddrW;

  logic [Width-1:0] entry_q [Depth];
  logic [AddrW-1:0] wptr_q, wptr_d;
  logic [AddrW-1:0] rptr_q, rptr_d;
  logic [AddrW:0]   count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (AddrW + 1)'(Depth));
  assign head_o  = entry_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = wptr_q + AddrW'(1);
    end
    if (pop_i) begin
      rptr_d = rptr_q + AddrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + (AddrW + 1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (AddrW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hdl/pftc_front.sv =====
// Front end: takes directives, resolves references, tracks fan state and issues commands.
module pftc_front #(
  parameter int unsigned VertexDepth = 4096,
  parameter int unsigned IdxW        = 12,
  parameter int unsigned CmdW        = 44
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  pftc_in_if.sink                 dir_i,
  input  logic                    queue_full_i,
  output logic                    push_o,
  output logic [CmdW-1:0]         push_data_o,
  output logic                    wr_en_o,
  output logic [IdxW-1:0]         wr_addr_o,
  output pftc_pkg::vertex_t       wr_data_o
);

  localparam int unsigned CntW = $clog2(VertexDepth + 1);
  localparam int unsigned ResW = ((CntW > pftc_pkg::REF_W) ? CntW : pftc_pkg::REF_W) + 2;

  typedef struct packed {
    logic [IdxW-1:0]     a;
    logic [IdxW-1:0]     b;
    logic [IdxW-1:0]     c;
    pftc_pkg::meta_t     meta;
  } cmd_t;

  logic [CntW-1:0]                      total_q, total_d;
  logic signed [pftc_pkg::PAL_W-1:0]    palette_q, palette_d;
  logic [IdxW-1:0]                      apex_q, apex_d;
  logic [IdxW-1:0]                      prev_q, prev_d;
  logic [1:0]                           corners_q, corners_d;
  logic                                 pending_q, pending_d;
  logic                                 err_q, err_d;

  logic                                 accept;
  logic                                 store_full;
  logic                                 face_pend;
  logic [1:0]                           eff_corners;
  logic signed [ResW-1:0]               ref_s;
  logic signed [ResW-1:0]               tot_s;
  logic signed [ResW-1:0]               res_s;
  logic                                 in_range;
  logic [IdxW-1:0]                      cur;
  cmd_t                                 cmd;

  assign dir_i.ready = err_q || !queue_full_i;
  assign accept      = dir_i.valid && dir_i.ready;

  assign store_full  = (total_q == CntW'(VertexDepth));
  assign face_pend   = pending_q || dir_i.first_of_face;
  assign eff_corners = face_pend ? 2'd0 : corners_q;

  assign ref_s    = ResW'(dir_i.vertex_ref);
  assign tot_s    = ResW'(total_q);
  assign res_s    = ref_s[ResW-1] ? (tot_s + ref_s) : (ref_s - ResW'(1));
  assign in_range = !res_s[ResW-1] && (res_s < tot_s);
  assign cur      = res_s[IdxW-1:0];

  assign wr_en_o   = accept && !err_q && (dir_i.opcode == pftc_pkg::OP_VERTEX) && !store_full;
  assign wr_addr_o = total_q[IdxW-1:0];
  assign wr_data_o = '{x: dir_i.pos_x, y: dir_i.pos_y, z: dir_i.pos_z};

  assign push_data_o = cmd;

  always_comb begin
    total_d   = total_q;
    palette_d = palette_q;
    apex_d    = apex_q;
    prev_d    = prev_q;
    corners_d = corners_q;
    pending_d = pending_q;
    err_d     = err_q;
    push_o    = 1'b0;
    cmd       = '0;
    if (accept && !err_q) begin
      unique case (pftc_pkg::op_e'(dir_i.opcode))
        pftc_pkg::OP_VERTEX: begin
          if (store_full) begin
            push_o         = 1'b1;
            cmd.meta.kind  = pftc_pkg::KIND_ERR;
            cmd.meta.code  = pftc_pkg::ERR_FULL;
            err_d          = 1'b1;
          end else begin
            total_d = total_q + CntW'(1);
          end
        end
        pftc_pkg::OP_PALETTE: begin
          palette_d = dir_i.palette_in[pftc_pkg::PAL_W-1] ? pftc_pkg::PAL_FALLBACK
                                                           : dir_i.palette_in;
        end
        pftc_pkg::OP_FACE: begin
          if (dir_i.vertex_ref == '0) begin
            pending_d = face_pend;
          end else if (!in_range) begin
            push_o        = 1'b1;
            cmd.meta.kind = pftc_pkg::KIND_ERR;
            cmd.meta.code = pftc_pkg::ERR_RANGE;
            err_d         = 1'b1;
          end else begin
            pending_d = 1'b0;
            priority if (eff_corners == 2'd0) begin
              apex_d    = cur;
              corners_d = 2'd1;
            end else if (eff_corners == 2'd1) begin
              prev_d    = cur;
              corners_d = 2'd2;
            end else begin
              push_o           = 1'b1;
              cmd.a            = apex_q;
              cmd.b            = prev_q;
              cmd.c            = cur;
              cmd.meta.kind    = pftc_pkg::KIND_TRI;
              cmd.meta.code    = pftc_pkg::ERR_RANGE;
              cmd.meta.palette = palette_q;
              prev_d           = cur;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q   <= '0;
      palette_q <= pftc_pkg::PAL_FALLBACK;
      apex_q    <= '0;
      prev_q    <= '0;
      corners_q <= '0;
      pending_q <= 1'b0;
      err_q     <= 1'b0;
    end else begin
      total_q   <= total_d;
      palette_q <= palette_d;
      apex_q    <= apex_d;
      prev_q    <= prev_d;
      corners_q <= corners_d;
      pending_q <= pending_d;
      err_q     <= err_d;
    end
  end

endmodule

// ===== hdl/pftc_back.sv =====
// Back end: vertex store, cross-product culling sequencer and result register.
module pftc_back #(
  parameter int unsigned VertexDepth = 4096,
  parameter int unsigned IdxW        = 12,
  parameter int unsigned CmdW        = 44
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pftc_pkg::THR_W-1:0]    cfg_wdata_i,
  input  logic                          wr_en_i,
  input  logic [IdxW-1:0]               wr_addr_i,
  input  pftc_pkg::vertex_t             wr_data_i,
  input  logic                          empty_i,
  input  logic [CmdW-1:0]               head_i,
  output logic                          pop_o,
  pftc_out_if.source                    res_o
);

  typedef struct packed {
    logic [IdxW-1:0]     a;
    logic [IdxW-1:0]     b;
    logic [IdxW-1:0]     c;
    pftc_pkg::meta_t     meta;
  } cmd_t;

  pftc_pkg::vertex_t   mem [VertexDepth];
  pftc_pkg::vertex_t   rd_q;
  logic [IdxW-1:0]     rd_addr;

  pftc_pkg::back_state_e state_q, state_d;
  cmd_t                  cmd_q;
  cmd_t                  head;
  logic [pftc_pkg::THR_W-1:0] thr_q;

  pftc_pkg::vertex_t   va_q, vb_q;
  logic signed [pftc_pkg::EDGE_W-1:0]  e1x_q, e1y_q, e1z_q, e2x_q, e2y_q, e2z_q;
  logic signed [pftc_pkg::PROD_W-1:0]  pyz_q, pzy_q, pzx_q, pxz_q, pxy_q, pyx_q;
  logic signed [pftc_pkg::CROSS_W-1:0] cx_q, cy_q, cz_q;
  logic [pftc_pkg::CROSS_W-1:0]        ax, ay, az;
  logic [pftc_pkg::MAG_W-1:0]          mx_q, my_q, mz_q;
  logic                                big_q, big_sq_q;
  logic [pftc_pkg::SQ_W-1:0]           sx_q, sy_q, sz_q;
  logic [pftc_pkg::SUM_W-1:0]          mag2;
  logic                                keep;

  logic                                out_free;
  logic                                load_out;
  logic                                out_valid_q;
  logic                                out_kind_q;
  logic [pftc_pkg::CORNER_W-1:0]       out_a_q, out_b_q, out_c_q;
  logic signed [pftc_pkg::PAL_W-1:0]   out_pal_q;
  logic                                out_code_q;

  assign head = cmd_t'(head_i);

  // Vertex store: written by the front end, one registered read port here.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= pftc_pkg::THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  assign ax = cx_q[pftc_pkg::CROSS_W-1] ? pftc_pkg::CROSS_W'(-cx_q) : pftc_pkg::CROSS_W'(cx_q);
  assign ay = cy_q[pftc_pkg::CROSS_W-1] ? pftc_pkg::CROSS_W'(-cy_q) : pftc_pkg::CROSS_W'(cy_q);
  assign az = cz_q[pftc_pkg::CROSS_W-1] ? pftc_pkg::CROSS_W'(-cz_q) : pftc_pkg::CROSS_W'(cz_q);

  assign mag2 = pftc_pkg::SUM_W'(sx_q) + pftc_pkg::SUM_W'(sy_q) + pftc_pkg::SUM_W'(sz_q);
  // A component of 2^32 or more squares past any threshold.
  assign keep = big_sq_q || (mag2 >= pftc_pkg::SUM_W'(thr_q));

  assign out_free = !out_valid_q || res_o.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pftc_pkg::B_IDLE: begin
        if (!empty_i) begin
          state_d = (head.meta.kind == pftc_pkg::KIND_ERR) ? pftc_pkg::B_OUT
                                                           : pftc_pkg::B_RDA;
        end
      end
      pftc_pkg::B_RDA:   state_d = pftc_pkg::B_RDB;
      pftc_pkg::B_RDB:   state_d = pftc_pkg::B_RDC;
      pftc_pkg::B_RDC:   state_d = pftc_pkg::B_EDGE;
      pftc_pkg::B_EDGE:  state_d = pftc_pkg::B_MUL;
      pftc_pkg::B_MUL:   state_d = pftc_pkg::B_CROSS;
      pftc_pkg::B_CROSS: state_d = pftc_pkg::B_ABS;
      pftc_pkg::B_ABS:   state_d = pftc_pkg::B_SQR;
      pftc_pkg::B_SQR:   state_d = pftc_pkg::B_SUM;
      pftc_pkg::B_SUM:   state_d = keep ? pftc_pkg::B_OUT : pftc_pkg::B_IDLE;
      pftc_pkg::B_OUT: begin
        if (out_free) begin
          state_d = pftc_pkg::B_IDLE;
        end
      end
      default: state_d = pftc_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = (state_q == pftc_pkg::B_IDLE) && !empty_i;
    load_out = (state_q == pftc_pkg::B_OUT) && out_free;
    unique case (state_q)
      pftc_pkg::B_RDB: rd_addr = cmd_q.b;
      pftc_pkg::B_RDC: rd_addr = cmd_q.c;
      default:         rd_addr = cmd_q.a;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pftc_pkg::B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= head;
    end
    if (state_q == pftc_pkg::B_RDB) begin
      va_q <= rd_q;
    end
    if (state_q == pftc_pkg::B_RDC) begin
      vb_q <= rd_q;
    end
    if (state_q == pftc_pkg::B_EDGE) begin
      e1x_q <= pftc_pkg::EDGE_W'(vb_q.x) - pftc_pkg::EDGE_W'(va_q.x);
      e1y_q <= pftc_pkg::EDGE_W'(vb_q.y) - pftc_pkg::EDGE_W'(va_q.y);
      e1z_q <= pftc_pkg::EDGE_W'(vb_q.z) - pftc_pkg::EDGE_W'(va_q.z);
      e2x_q <= pftc_pkg::EDGE_W'(rd_q.x) - pftc_pkg::EDGE_W'(va_q.x);
      e2y_q <= pftc_pkg::EDGE_W'(rd_q.y) - pftc_pkg::EDGE_W'(va_q.y);
      e2z_q <= pftc_pkg::EDGE_W'(rd_q.z) - pftc_pkg::EDGE_W'(va_q.z);
    end
    if (state_q == pftc_pkg::B_MUL) begin
      pyz_q <= pftc_pkg::PROD_W'(e1y_q) * pftc_pkg::PROD_W'(e2z_q);
      pzy_q <= pftc_pkg::PROD_W'(e1z_q) * pftc_pkg::PROD_W'(e2y_q);
      pzx_q <= pftc_pkg::PROD_W'(e1z_q) * pftc_pkg::PROD_W'(e2x_q);
      pxz_q <= pftc_pkg::PROD_W'(e1x_q) * pftc_pkg::PROD_W'(e2z_q);
      pxy_q <= pftc_pkg::PROD_W'(e1x_q) * pftc_pkg::PROD_W'(e2y_q);
      pyx_q <= pftc_pkg::PROD_W'(e1y_q) * pftc_pkg::PROD_W'(e2x_q);
    end
    if (state_q == pftc_pkg::B_CROSS) begin
      cx_q <= pftc_pkg::CROSS_W'(pyz_q) - pftc_pkg::CROSS_W'(pzy_q);
      cy_q <= pftc_pkg::CROSS_W'(pzx_q) - pftc_pkg::CROSS_W'(pxz_q);
      cz_q <= pftc_pkg::CROSS_W'(pxy_q) - pftc_pkg::CROSS_W'(pyx_q);
    end
    if (state_q == pftc_pkg::B_ABS) begin
      mx_q  <= ax[pftc_pkg::MAG_W-1:0];
      my_q  <= ay[pftc_pkg::MAG_W-1:0];
      mz_q  <= az[pftc_pkg::MAG_W-1:0];
      big_q <= (ax[pftc_pkg::CROSS_W-1:pftc_pkg::MAG_W] != '0)
            || (ay[pftc_pkg::CROSS_W-1:pftc_pkg::MAG_W] != '0)
            || (az[pftc_pkg::CROSS_W-1:pftc_pkg::MAG_W] != '0);
    end
    if (state_q == pftc_pkg::B_SQR) begin
      sx_q     <= pftc_pkg::SQ_W'(mx_q) * pftc_pkg::SQ_W'(mx_q);
      sy_q     <= pftc_pkg::SQ_W'(my_q) * pftc_pkg::SQ_W'(my_q);
      sz_q     <= pftc_pkg::SQ_W'(mz_q) * pftc_pkg::SQ_W'(mz_q);
      big_sq_q <= big_q;
    end
    if (load_out) begin
      out_kind_q <= cmd_q.meta.kind;
      out_code_q <= cmd_q.meta.code;
      if (cmd_q.meta.kind == pftc_pkg::KIND_ERR) begin
        out_a_q   <= '0;
        out_b_q   <= '0;
        out_c_q   <= '0;
        out_pal_q <= '0;
      end else begin
        out_a_q   <= pftc_pkg::CORNER_W'(cmd_q.a);
        out_b_q   <= pftc_pkg::CORNER_W'(cmd_q.b);
        out_c_q   <= pftc_pkg::CORNER_W'(cmd_q.c);
        out_pal_q <= cmd_q.meta.palette;
      end
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.kind        = out_kind_q;
  assign res_o.corner_a    = out_a_q;
  assign res_o.corner_b    = out_b_q;
  assign res_o.corner_c    = out_c_q;
  assign res_o.tri_palette = out_pal_q;
  assign res_o.error_code  = out_code_q;

endmodule

// ===== hdl/polygon_fan_triangulator_culling_unit.sv =====
// Top level of the polygon fan triangulator with degenerate-triangle culling.
//
//  Channel    Direction  Handshake         Carries
//  dir_i      in         valid/ready       one mesh directive per transaction
//  res_o      out        valid/ready       one triangle or error report per transaction
//  cfg_we_i   in         write enable      degenerate_threshold (63 bits) on cfg_wdata_i
//
// The front end takes one directive transaction per cycle while its command queue has room.
// A fan triangle passes the back end in steps: three reads through the single
// read port of the vertex store, then edge, product, cross, magnitude, square and sum steps.
// An error report goes from idle straight to the output step. There is no clearing pass after reset.
// A stalled result stays in the output register while the front end fills its queue.
module polygon_fan_triangulator_culling_unit #(
  parameter int unsigned VertexDepth = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pftc_pkg::THR_W-1:0]    cfg_wdata_i,
  pftc_in_if.sink                       dir_i,
  pftc_out_if.source                    res_o
);

  // Vertex indices are as wide as the store needs; reported corners keep their low twelve bits.
  localparam int unsigned IdxW = $clog2(VertexDepth);
  localparam int unsigned CmdW = 3 * IdxW + $bits(pftc_pkg::meta_t);

  logic              push;
  logic [CmdW-1:0]   push_data;
  logic              pop;
  logic [CmdW-1:0]   head;
  logic              q_empty;
  logic              q_full;
  logic              wr_en;
  logic [IdxW-1:0]   wr_addr;
  pftc_pkg::vertex_t wr_data;

  // The front end resolves references and keeps the fan state, so every triangle it queues
  // already names the three corners; once an error is queued it drops all later directives.
  pftc_front #(
    .VertexDepth (VertexDepth),
    .IdxW        (IdxW),
    .CmdW        (CmdW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .dir_i        (dir_i),
    .queue_full_i (q_full),
    .push_o       (push),
    .push_data_o  (push_data),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data)
  );

  pftc_queue #(
    .Width (CmdW),
    .AddrW (pftc_pkg::QUEUE_AW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  // The store only ever grows, so an entry the back end reads was written before the command
  // that names it entered the queue.
  pftc_back #(
    .VertexDepth (VertexDepth),
    .IdxW        (IdxW),
    .CmdW        (CmdW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .empty_i     (q_empty),
    .head_i      (head),
    .pop_o       (pop),
    .res_o       (res_o)
  );

endmodule

// ===== hdl/pftc_sva.sv =====
// Port-level checks on the result channel of the triangulator, bound to the top level.
module pftc_sva (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic                                kind_i,
  input logic [pftc_pkg::CORNER_W-1:0]       corner_a_i,
  input logic [pftc_pkg::CORNER_W-1:0]       corner_b_i,
  input logic [pftc_pkg::CORNER_W-1:0]       corner_c_i,
  input logic signed [pftc_pkg::PAL_W-1:0]   tri_palette_i,
  input logic                                error_code_i
);

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) && $stable(corner_a_i)
      && $stable(corner_b_i) && $stable(corner_c_i) && $stable(tri_palette_i)
      && $stable(error_code_i))
    else $error("result payload changed while stalled");

  // An error report is the last result; nothing follows it straight away.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && (kind_i == pftc_pkg::KIND_ERR) |=> !out_valid_i)
    else $error("result offered after an error report");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == pftc_pkg::KIND_ERR) |-> (corner_a_i == '0)
      && (corner_b_i == '0) && (corner_c_i == '0) && (tri_palette_i == '0))
    else $error("error report carries triangle fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == pftc_pkg::KIND_TRI) |-> (error_code_i == pftc_pkg::ERR_RANGE))
    else $error("triangle carries an error code");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == pftc_pkg::KIND_TRI) |->
      (!tri_palette_i[pftc_pkg::PAL_W-1]) || (tri_palette_i == pftc_pkg::PAL_FALLBACK))
    else $error("triangle palette tag out of range");

endmodule

bind polygon_fan_triangulator_culling_unit pftc_sva u_pftc_sva (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .kind_i        (res_o.kind),
  .corner_a_i    (res_o.corner_a),
  .corner_b_i    (res_o.corner_b),
  .corner_c_i    (res_o.corner_c),
  .tri_palette_i (res_o.tri_palette),
  .error_code_i  (res_o.error_code)
);
